FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the buffer release tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define MRBRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define MRBRT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/mrbrt_pkg.sv
// Shared types and constants of the multi-reader buffer release tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mrbrt_pkg;

    localparam int NUM_BUFFERS_DEF = 4;
    localparam int NUM_READERS_DEF = 8;

    localparam int KIND_W     = 3;
    localparam int READER_W   = 3;
    localparam int BIDX_W     = 32;
    localparam int SEQ_W      = 64;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int GBUF_W     = 2;
    localparam int OMASK_W    = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ACTIVE = 8'd1;

    typedef enum logic [KIND_W-1:0] {
        K_ATTACH  = 3'd0,
        K_REMOVE  = 3'd1,
        K_PUBLISH = 3'd2,
        K_ACK     = 3'd3,
        K_TICK    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DONE
    } t_state;

    // Sequencer to buffer pool
    typedef struct packed {
        logic              load;
        logic              step;
        logic [KIND_W-1:0] kind;
    } t_ctl;

    // Result fields as seen on the ports
    typedef struct packed {
        logic               ok;
        logic [GBUF_W-1:0]  granted_buffer;
        logic [SEQ_W-1:0]   granted_sequence;
        logic [OMASK_W-1:0] evicted_readers;
        logic [OMASK_W-1:0] active_readers;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/mrbrt_seq.sv
// Sequencer of the release tracker: accepts an item and walks the buffer index.
// Depends on mrbrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrbrt_seq
    import mrbrt_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [BIDX_W-1:0] i_buffer_index,
    output logic                   o_busy,
    output logic                   o_done,
    output t_ctl                   o_ctl,
    output logic [IDX_W-1:0]       o_idx
);

    t_state            r_state, n_state;
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic              w_accept;
    logic              w_last;

    assign w_accept = i_start && (r_state == S_IDLE);
    // publish and tick visit every buffer; the rest take a single step
    assign w_last = !((r_kind == K_PUBLISH) || (r_kind == K_TICK))
                    || (r_idx == IDX_W'(NUM_BUFFERS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_STEP;
            end
            S_STEP: begin
                if (w_last) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy     = (r_state != S_IDLE);
        o_done     = (r_state == S_DONE);
        o_ctl.load = w_accept;
        o_ctl.step = (r_state == S_STEP);
        o_ctl.kind = r_kind;
        o_idx      = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_idx  <= (i_kind == K_ACK) ? i_buffer_index[IDX_W-1:0] : '0;
        end else if ((r_state == S_STEP) && !w_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mrbrt_pool.sv
// Buffer pool of the release tracker: pending masks, stamps, reader mask and
// the shared age compare, driven one buffer per step. Depends on mrbrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrbrt_pool
    import mrbrt_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int NUM_READERS = NUM_READERS_DEF,
    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl                 i_ctl,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic [READER_W-1:0]  i_reader,
    input  wire logic [BIDX_W-1:0]    i_buffer_index,
    input  wire logic [SEQ_W-1:0]     i_ack_sequence,
    input  wire logic [TIME_W-1:0]    i_now_ms,
    input  wire logic [TIMEOUT_W-1:0] i_timeout,
    input  wire logic                 i_feed_active,
    output t_res                      o_res
);

    logic [NUM_READERS-1:0] r_pend [NUM_BUFFERS];
    logic [NUM_READERS-1:0] n_pend [NUM_BUFFERS];
    logic [SEQ_W-1:0]       r_seq  [NUM_BUFFERS];
    logic [TIME_W-1:0]      r_time [NUM_BUFFERS];

    logic [NUM_READERS-1:0] r_active, n_active;
    logic [SEQ_W-1:0]       r_cnt, n_cnt;
    logic                   r_ok, n_ok;
    logic [IDX_W-1:0]       r_gbuf, n_gbuf;
    logic [SEQ_W-1:0]       r_gseq, n_gseq;
    logic [NUM_READERS-1:0] r_evict, n_evict;
    logic                   r_found, n_found;

    // item payload held for the walk
    logic [NUM_READERS-1:0] r_rbit;
    logic                   r_ack_ok;
    logic [SEQ_W-1:0]       r_aseq;
    logic [TIME_W-1:0]      r_now;

    logic [NUM_READERS-1:0] w_pend_cur;
    logic [TIME_W-1:0]      w_age;
    logic                   w_expired;
    logic                   w_seq_hit;
    logic [SEQ_W-1:0]       w_seq_next;
    logic                   w_stamp;

    assign w_pend_cur = r_pend[i_idx];
    assign w_age      = r_now - r_time[i_idx];
    assign w_expired  = (w_pend_cur != '0) && (w_age >= TIME_W'(i_timeout));
    assign w_seq_hit  = (r_seq[i_idx] == r_aseq);
    assign w_seq_next = r_cnt + SEQ_W'(1);

    always_comb begin
        for (int b = 0; b < NUM_BUFFERS; b++) begin
            n_pend[b] = r_pend[b];
        end
        n_active = r_active;
        n_cnt    = r_cnt;
        n_ok     = r_ok;
        n_gbuf   = r_gbuf;
        n_gseq   = r_gseq;
        n_evict  = r_evict;
        n_found  = r_found;
        w_stamp  = 1'b0;
        if (i_ctl.load) begin
            n_ok    = 1'b0;
            n_gbuf  = '0;
            n_gseq  = '0;
            n_evict = '0;
            n_found = 1'b0;
        end else if (i_ctl.step) begin
            unique case (i_ctl.kind)
                K_ATTACH: begin
                    n_active = r_active | r_rbit;
                end
                K_REMOVE: begin
                    for (int b = 0; b < NUM_BUFFERS; b++) begin
                        n_pend[b] = r_pend[b] & ~r_rbit;
                    end
                    n_active = r_active & ~r_rbit;
                end
                K_PUBLISH: begin
                    // take the first free buffer met on the walk, skip the rest
                    if (i_feed_active && (r_active != '0) && !r_found
                            && (w_pend_cur == '0)) begin
                        w_stamp        = 1'b1;
                        n_cnt          = w_seq_next;
                        n_pend[i_idx]  = r_active;
                        n_ok           = 1'b1;
                        n_gbuf         = i_idx;
                        n_gseq         = w_seq_next;
                        n_found        = 1'b1;
                    end
                end
                K_ACK: begin
                    if (r_ack_ok && w_seq_hit) begin
                        n_ok          = ((w_pend_cur & r_rbit) != '0);
                        n_pend[i_idx] = w_pend_cur & ~r_rbit;
                    end
                end
                K_TICK: begin
                    // drop the late readers everywhere; later buffers see the drop
                    if (w_expired) begin
                        n_evict = r_evict | w_pend_cur;
                        for (int b = 0; b < NUM_BUFFERS; b++) begin
                            n_pend[b] = r_pend[b] & ~w_pend_cur;
                        end
                        n_active = r_active & ~w_pend_cur;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUFFERS; b++) begin
                r_pend[b] <= '0;
                r_seq[b]  <= '0;
            end
            r_active <= '0;
            r_cnt    <= '0;
        end else begin
            for (int b = 0; b < NUM_BUFFERS; b++) begin
                r_pend[b] <= n_pend[b];
            end
            if (w_stamp) begin
                r_seq[i_idx] <= w_seq_next;
            end
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stamp) begin
            r_time[i_idx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_gbuf  <= n_gbuf;
        r_gseq  <= n_gseq;
        r_evict <= n_evict;
        r_found <= n_found;
        if (i_ctl.load) begin
            r_rbit   <= (32'(i_reader) < 32'(NUM_READERS))
                        ? (NUM_READERS'(1) << i_reader) : '0;
            r_ack_ok <= (32'(i_reader) < 32'(NUM_READERS))
                        && (i_buffer_index < BIDX_W'(NUM_BUFFERS));
            r_aseq   <= i_ack_sequence;
            r_now    <= i_now_ms;
        end
    end

    always_comb begin
        o_res.ok               = r_ok;
        o_res.granted_buffer   = GBUF_W'(r_gbuf);
        o_res.granted_sequence = r_gseq;
        o_res.evicted_readers  = OMASK_W'(r_evict);
        o_res.active_readers   = OMASK_W'(r_active);
    end

endmodule

`default_nettype wire

FILE: hdl/multi_reader_buffer_release_tracker_top.sv
// Multi-reader buffer release tracker, top level with configuration registers.
// Depends on mrbrt_pkg, mrbrt_seq and mrbrt_pool.
//
// An item is taken when start is high and busy is low. Attach, remove, acknowledge
// and unknown kinds go from S_STEP straight to S_DONE with their result; publish
// and tick walk the pool one buffer per cycle through the shared age compare and
// reach S_DONE after the last buffer. The result stands on the o_ ports for one
// cycle with o_valid high and cannot be held off by the receiver; busy falls in
// the following cycle. The configuration port is ready only while busy and start
// are both low, so the registers never change under an item in flight.
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_buffer_release_tracker_top
    import mrbrt_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int NUM_READERS = NUM_READERS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [READER_W-1:0]   i_reader,
    input  wire logic [BIDX_W-1:0]     i_buffer_index,
    input  wire logic [SEQ_W-1:0]      i_ack_sequence,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic                       o_ok,
    output logic [GBUF_W-1:0]          o_granted_buffer,
    output logic [SEQ_W-1:0]           o_granted_sequence,
    output logic [OMASK_W-1:0]         o_evicted_readers,
    output logic [OMASK_W-1:0]         o_active_readers
);

    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_feed_active;
    t_ctl                 w_ctl;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_done;
    t_res                 w_res;

    // hold register writes off while an item is taken or in flight
    assign o_cfg_ready = !busy && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= TIMEOUT_RESET;
            r_feed_active <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ACK_TIMEOUT: r_timeout     <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_FEED_ACTIVE: r_feed_active <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mrbrt_seq #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_kind         (i_kind),
        .i_buffer_index (i_buffer_index),
        .o_busy         (busy),
        .o_done         (w_done),
        .o_ctl          (w_ctl),
        .o_idx          (w_idx)
    );

    mrbrt_pool #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NUM_READERS (NUM_READERS)
    ) u_pool (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_idx          (w_idx),
        .i_reader       (i_reader),
        .i_buffer_index (i_buffer_index),
        .i_ack_sequence (i_ack_sequence),
        .i_now_ms       (i_now_ms),
        .i_timeout      (r_timeout),
        .i_feed_active  (r_feed_active),
        .o_res          (w_res)
    );

    assign o_valid            = w_done;
    assign o_ok               = w_res.ok;
    assign o_granted_buffer   = w_res.granted_buffer;
    assign o_granted_sequence = w_res.granted_sequence;
    assign o_evicted_readers  = w_res.evicted_readers;
    assign o_active_readers   = w_res.active_readers;

endmodule

`default_nettype wire

FILE: hdl/mrbrt_chk.sv
// Port-level checker of the release tracker, bound to the top level.
// Depends on mrbrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mrbrt_chk
    import mrbrt_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic               o_ok,
    input wire logic [GBUF_W-1:0]  o_granted_buffer,
    input wire logic [SEQ_W-1:0]   o_granted_sequence,
    input wire logic [OMASK_W-1:0] o_evicted_readers,
    input wire logic [OMASK_W-1:0] o_active_readers
);

    `MRBRT_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "item taken but not busy")
    `MRBRT_ASSERT(a_strobe_once, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe held")
    `MRBRT_ASSERT(a_fail_clean, i_clk, i_rst_n, (o_valid && !o_ok) |-> ((o_granted_sequence == '0) && (o_granted_buffer == '0)), "grant on a failed item")
    `MRBRT_ASSERT(a_evict_gone, i_clk, i_rst_n, o_valid |-> ((o_active_readers & o_evicted_readers) == '0), "evicted reader still active")
    `MRBRT_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> (!busy && !o_valid), "activity after reset")

endmodule

bind multi_reader_buffer_release_tracker_top mrbrt_chk u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_ok               (o_ok),
    .o_granted_buffer   (o_granted_buffer),
    .o_granted_sequence (o_granted_sequence),
    .o_evicted_readers  (o_evicted_readers),
    .o_active_readers   (o_active_readers)
);

`default_nettype wire
